FILE: src/pxr_pkg.sv
package pxr_pkg;

  localparam int CNT_W = 5;

  typedef struct packed {
    logic [15:0] proposal_number;
    logic [63:0] proposed_value;
  } req_t;

  typedef struct packed {
    logic        chosen;
    logic [2:0]  promise_votes;
    logic [2:0]  accept_votes;
    logic [63:0] agreed_value;
    logic        took_prior_value;
  } res_t;

  typedef enum logic {
    PH_PREP = 1'b0,
    PH_ACC  = 1'b1
  } phase_t;

  typedef struct packed {
    logic             valid;
    phase_t           phase;
    logic             have_prior;
    logic [CNT_W-1:0] count;
  } ctl_t;

  function automatic logic [2:0] sat3(input logic [CNT_W-1:0] n);
    sat3 = (n > CNT_W'(7)) ? 3'd7 : n[2:0];
  endfunction

endpackage

FILE: src/paxos_round_over_acceptors.sv
// One Paxos round over a row of acceptor cells per command.
// A command beat is taken when start is high and busy is low; request carries
// the proposal number and the proposer's value. busy stays high until the
// round is over. The result beat is marked by strobe, high for exactly one cycle;
// the receiver cannot stall it and strobe is never held.
// The round sends a prepare beat down the row of ACCEPTORS cells, one cell
// per cycle, each cell promising if the number beats its last promise and handing on the best prior value so far.
// If a strict majority promised, an accept beat walks the row the same way.
// With a majority, strobe rises once the prepare beat and then the accept
// beat have passed the row; without one, once the prepare beat alone has.
// A new command may be given in the cycle that strobe is high,
// so rounds can run back to back.
// Reset clears every acceptor to nothing promised and nothing accepted,
// drops busy and strobe, and abandons any round in flight.
module paxos_round_over_acceptors
  import pxr_pkg::*;
#(
  parameter int ACCEPTORS   = 5,
  parameter int VALUE_BITS  = 64,
  parameter int NUMBER_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  localparam logic [CNT_W-1:0] MAJ = CNT_W'(ACCEPTORS / 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_ACC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  ctl_t                   link_ctl  [0:ACCEPTORS];
  logic [NUMBER_BITS-1:0] link_best [0:ACCEPTORS];
  logic [VALUE_BITS-1:0]  link_val  [0:ACCEPTORS];

  ctl_t                   head_ctl;
  ctl_t                   head_ctl_next;
  logic                   strobe_next;
  logic [VALUE_BITS-1:0]  head_val;
  logic [NUMBER_BITS-1:0] number;
  logic [2:0]             promises;
  logic                   prior;
  logic [31:0]            num_ext;
  ctl_t                   tail;
  logic                   majority;

  assign num_ext      = 32'(request.proposal_number);
  assign link_ctl[0]  = head_ctl;
  assign link_best[0] = '0;
  assign link_val[0]  = head_val;
  assign tail         = link_ctl[ACCEPTORS];
  assign majority     = tail.count > MAJ;
  assign busy         = (state != ST_IDLE);

  for (genvar i = 0; i < ACCEPTORS; i++) begin : g_cell
    pxr_cell #(
      .NUMBER_BITS(NUMBER_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .number  (number),
      .ctl_in  (link_ctl[i]),
      .best_in (link_best[i]),
      .val_in  (link_val[i]),
      .ctl_out (link_ctl[i+1]),
      .best_out(link_best[i+1]),
      .val_out (link_val[i+1])
    );
  end

  always_comb begin
    state_next    = state;
    head_ctl_next = '0;
    strobe_next   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          head_ctl_next = '{valid: 1'b1, phase: PH_PREP, have_prior: 1'b0, count: '0};
          state_next    = ST_PREP;
        end
      end
      ST_PREP: begin
        if (tail.valid) begin
          if (majority) begin
            head_ctl_next = '{valid: 1'b1, phase: PH_ACC, have_prior: 1'b0, count: '0};
            state_next    = ST_ACC;
          end else begin
            strobe_next = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      ST_ACC: begin
        if (tail.valid) begin
          strobe_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head_ctl <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      head_ctl <= head_ctl_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      number   <= num_ext[NUMBER_BITS-1:0];
      head_val <= request.proposed_value[VALUE_BITS-1:0];
    end
    if ((state == ST_PREP) && tail.valid) begin
      promises <= sat3(tail.count);
      prior    <= tail.have_prior;
      head_val <= link_val[ACCEPTORS];
      if (!majority) begin
        result <= '{chosen: 1'b0, promise_votes: sat3(tail.count), accept_votes: 3'd0,
                    agreed_value: 64'd0, took_prior_value: 1'b0};
      end
    end
    if ((state == ST_ACC) && tail.valid) begin
      result <= '{chosen: majority, promise_votes: promises, accept_votes: sat3(tail.count),
                  agreed_value: 64'(link_val[ACCEPTORS]), took_prior_value: prior};
    end
  end

  a_strobe_after_round: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state != ST_IDLE))
    else $error("result beat without a round in progress");

  a_tail_while_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state != ST_IDLE))
    else $error("row beat arrived while idle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_chosen_votes: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.chosen) |-> (result.promise_votes != 3'd0 &&
                                   result.accept_votes != 3'd0))
    else $error("chosen without votes");

endmodule

FILE: src/pxr_cell.sv
module pxr_cell
  import pxr_pkg::*;
#(
  parameter int NUMBER_BITS = 16,
  parameter int VALUE_BITS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [NUMBER_BITS-1:0] number,
  input  ctl_t                   ctl_in,
  input  logic [NUMBER_BITS-1:0] best_in,
  input  logic [VALUE_BITS-1:0]  val_in,
  output ctl_t                   ctl_out,
  output logic [NUMBER_BITS-1:0] best_out,
  output logic [VALUE_BITS-1:0]  val_out
);

  logic                   prom_set;
  logic [NUMBER_BITS-1:0] prom;
  logic [NUMBER_BITS-1:0] acc_num;
  logic                   value_valid;
  logic [VALUE_BITS-1:0]  token;

  logic promise;
  logic better;
  logic accept;

  ctl_t                   ctl_out_next;
  logic [NUMBER_BITS-1:0] best_out_next;
  logic [VALUE_BITS-1:0]  val_out_next;

  always_comb begin
    promise = ctl_in.valid && (ctl_in.phase == PH_PREP) && (!prom_set || (number > prom));
    better  = promise && value_valid && (!ctl_in.have_prior || (acc_num > best_in));
    accept  = ctl_in.valid && (ctl_in.phase == PH_ACC) && (!prom_set || (prom <= number));
    ctl_out_next = ctl_in;
    if (promise || accept) begin
      ctl_out_next.count = ctl_in.count + CNT_W'(1);
    end
    if (better) begin
      ctl_out_next.have_prior = 1'b1;
    end
    best_out_next = better ? acc_num : best_in;
    val_out_next  = better ? token : val_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out     <= '0;
      prom_set    <= 1'b0;
      value_valid <= 1'b0;
    end else begin
      ctl_out <= ctl_out_next;
      if (promise || accept) begin
        prom_set <= 1'b1;
      end
      if (accept) begin
        value_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_out <= best_out_next;
    val_out  <= val_out_next;
    if (promise || accept) begin
      prom <= number;
    end
    if (accept) begin
      acc_num <= number;
      token   <= val_in;
    end
  end

endmodule

FILE: sim/paxos_round_checker.sv
module paxos_round_checker
  import pxr_pkg::*;
#(
  parameter int ACCEPTORS = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  res_t result,
  output int   outstanding,
  output int   mismatches
);

  int          promised_num [ACCEPTORS];
  int          accepted_num [ACCEPTORS];
  bit          holds_value  [ACCEPTORS];
  logic [63:0] stored_value [ACCEPTORS];
  res_t        expected_outcomes [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Runs one whole round on the acceptor copies and returns the outcome beat.
  function automatic res_t run_round(input req_t cmd);
    int          p;
    int          promises;
    int          accepts;
    bit          have_prior;
    int          best_num;
    logic [63:0] decided;
    res_t        r;
    p          = int'(cmd.proposal_number);
    promises   = 0;
    accepts    = 0;
    have_prior = 1'b0;
    best_num   = -1;
    decided    = cmd.proposed_value;
    r          = '0;
    for (int i = 0; i < ACCEPTORS; i++) begin
      if (p > promised_num[i]) begin
        promised_num[i] = p;
        promises++;
        if (holds_value[i] && (!have_prior || accepted_num[i] > best_num)) begin
          have_prior = 1'b1;
          best_num   = accepted_num[i];
          decided    = stored_value[i];
        end
      end
    end
    r.promise_votes = (promises > 7) ? 3'd7 : 3'(promises);
    if (promises > ACCEPTORS / 2) begin
      for (int i = 0; i < ACCEPTORS; i++) begin
        if (p >= promised_num[i]) begin
          promised_num[i] = p;
          accepted_num[i] = p;
          stored_value[i] = decided;
          holds_value[i]  = 1'b1;
          accepts++;
        end
      end
      r.chosen           = (accepts > ACCEPTORS / 2);
      r.accept_votes     = (accepts > 7) ? 3'd7 : 3'(accepts);
      r.agreed_value     = decided;
      r.took_prior_value = have_prior;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < ACCEPTORS; i++) begin
        promised_num[i] = -1;
        accepted_num[i] = -1;
        holds_value[i]  = 1'b0;
        stored_value[i] = '0;
      end
      expected_outcomes.delete();
    end else begin
      if (strobe) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result beat with no round pending", result.agreed_value, '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (result.chosen !== want.chosen)
            report_mismatch("chosen", result.chosen, want.chosen);
          if (result.promise_votes !== want.promise_votes)
            report_mismatch("promise_votes", result.promise_votes, want.promise_votes);
          if (result.accept_votes !== want.accept_votes)
            report_mismatch("accept_votes", result.accept_votes, want.accept_votes);
          if (result.agreed_value !== want.agreed_value)
            report_mismatch("agreed_value", result.agreed_value, want.agreed_value);
          if (result.took_prior_value !== want.took_prior_value)
            report_mismatch("took_prior_value", result.took_prior_value,
                            want.took_prior_value);
        end
      end
      if (start && !busy)
        expected_outcomes.insert(expected_outcomes.size(), run_round(request));
    end
    outstanding = expected_outcomes.size();
  end

endmodule

FILE: sim/paxos_round_over_acceptors_test.sv
module paxos_round_over_acceptors_test;
  import pxr_pkg::*;

  localparam int PHASE_ITEMS = 200;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic strobe;
  res_t result;
  int   outstanding;
  int   mismatches;
  int   sender_idle_pct;
  int   top_number;

  paxos_round_over_acceptors dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  paxos_round_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .strobe      (strobe),
    .result      (result),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic issue(input logic [15:0] num, input logic [63:0] val);
    @(negedge clk);
    start   <= 1'b1;
    request <= '{proposal_number: num, proposed_value: val};
    do @(posedge clk); while (busy);
    if (int'(num) > top_number) top_number = int'(num);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      repeat ($urandom_range(1, 26)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly rising numbers so that rounds keep succeeding; the rest repeat or
  // undercut the highest number so far and must be refused.
  task automatic random_round();
    int          pick;
    int          num;
    logic [63:0] val;
    pick = $urandom_range(99);
    if (pick < 60 && top_number < 65535 - 300) begin
      num = top_number + (($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(1, 300));
    end else if (pick < 75) begin
      num = top_number;
    end else begin
      num = $urandom_range(0, top_number);
    end
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = '1;
      default: val = {$urandom, $urandom};
    endcase
    sender_gap();
    issue(16'(num), val);
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    request         = '0;
    sender_idle_pct = 0;
    top_number      = -1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    issue(16'd0, '1);
    issue(16'd0, '0);
    issue(16'd1, '0);
    issue(16'd1, 64'h0123_4567_89ab_cdef);
    issue(16'd0, {$urandom, $urandom});
    issue(16'd2, '1);
    issue(16'd3, '0);
    issue(16'd2, {$urandom, $urandom});
    issue(16'd100, {$urandom, $urandom});
    drain();

    sender_idle_pct = 30;
    repeat (PHASE_ITEMS) random_round();
    drain();
    sender_idle_pct = 65;
    repeat (PHASE_ITEMS) random_round();
    drain();
    sender_idle_pct = 0;
    repeat (PHASE_ITEMS) random_round();

    issue(16'hffff, '1);
    issue(16'hffff, '0);
    issue(16'd0, {$urandom, $urandom});
    drain();
    repeat (40) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
